>>> rtl/dfl_pkg.sv
package dfl_pkg;

  localparam int MAX_TAPS    = 255;
  localparam int TAP_BITS    = $clog2(MAX_TAPS + 1);
  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_BITS  = 18;
  localparam int PROD_BITS   = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_BITS    = PROD_BITS + TAP_BITS;
  localparam int ROUND_SHIFT = COEFF_BITS - 1;
  localparam int ORDER_BITS  = 8;
  localparam int DECIM_BITS  = 5;
  localparam int PHASE_BITS  = 4;
  localparam int ACTION_BITS = 2;
  localparam int S_TDATA_BITS = 48;

  // action codes
  localparam logic [ACTION_BITS-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_SAMPLE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_START  = 2'd2;

  // register indexes
  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_DECIM = 1'b1;

  localparam logic [ORDER_BITS-1:0] ORDER_RESET = 8'd160;
  localparam logic [DECIM_BITS-1:0] DECIM_RESET = 5'd1;
  localparam logic [DECIM_BITS-1:0] DECIM_MAX   = 5'd16;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic                issue;
    logic                first;
    logic                last;
    logic                valid_tap;
    logic [TAP_BITS-1:0] coef_addr;
  } mac_ctrl_t;

  typedef struct packed {
    logic                         en;
    logic [TAP_BITS-1:0]          addr;
    logic signed [COEFF_BITS-1:0] data;
  } coef_wr_t;

  typedef struct packed {
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          sat;
  } mac_res_t;

endpackage

>>> rtl/decimating_fir_lowpass.sv
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | tuser: action; tdata: sample, coeff index, coeff
// m       | out | m_tvalid/m_tready | tuser: saturated; tdata: filtered sample
// cfg     | in  | cfg_we            | cfg_index, cfg_data
//
// loads, starts and samples with no output due leave the block idle, ready for the next item.
// for a computed sample one mac walks the full ring of 255 sample cells, one tap
// per cycle, whatever the filter order.
// rst is synchronous: clears the sample ring, counters and output valid, and sets the registers to their reset values.
// a held result does not stop the next item; only the next computed one waits.
module decimating_fir_lowpass import dfl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [ORDER_BITS-1:0]   cfg_data,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [S_TDATA_BITS-1:0] s_tdata,  // sample_value, coeff_index, coeff_value, pad
  input  logic [ACTION_BITS-1:0]  s_tuser,  // action
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [SAMPLE_BITS-1:0]  m_tdata,  // filtered_sample
  output logic [0:0]              m_tuser   // saturated
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]             state;
  logic [ORDER_BITS-1:0]  filter_order;
  logic [DECIM_BITS-1:0]  decimation_factor;
  logic [TAP_BITS-1:0]    line_pointer;
  logic [ORDER_BITS-1:0]  warmup_count;
  logic [PHASE_BITS-1:0]  decimation_phase;
  logic [TAP_BITS-1:0]    sweep_idx;
  logic [TAP_BITS-1:0]    coef_idx;

  logic                          s_accept;
  logic [ACTION_BITS-1:0]        action;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic [TAP_BITS-1:0]           coeff_index;
  logic signed [COEFF_BITS-1:0]  coeff_value;

  logic [TAP_BITS-1:0]   taps;
  logic [ORDER_BITS-1:0] delay;
  logic [DECIM_BITS-1:0] factor;
  logic [TAP_BITS-1:0]   lp_eff;
  logic [TAP_BITS-1:0]   lp_next;
  logic [DECIM_BITS-1:0] phase_eff;
  logic [DECIM_BITS-1:0] phase_inc;
  logic [TAP_BITS:0]     lp_inc;
  logic [TAP_BITS:0]     coef_inc;
  logic [TAP_BITS-1:0]   coef_start;
  logic                  sample_wr;
  logic                  out_load;

  cell_ctrl_t                    cell_ctrl;
  mac_ctrl_t                     mac_ctrl;
  coef_wr_t                      coef_wr;
  mac_res_t                      res;
  logic signed [SAMPLE_BITS-1:0] ring [MAX_TAPS];

  assign s_tready     = (state == ST_IDLE);
  assign s_accept     = s_tvalid && s_tready;
  assign action       = s_tuser;
  assign sample_value = $signed(s_tdata[SAMPLE_BITS-1:0]);
  assign coeff_index  = s_tdata[SAMPLE_BITS +: TAP_BITS];
  assign coeff_value  = $signed(s_tdata[SAMPLE_BITS+TAP_BITS +: COEFF_BITS]);
  // finished result moves into the output register
  assign out_load     = (state == ST_WAIT) && res.ready && (!m_tvalid || m_tready);

  always_comb begin
    taps   = (filter_order >= ORDER_BITS'(MAX_TAPS)) ? TAP_BITS'(MAX_TAPS)
                                                     : TAP_BITS'(filter_order + 1'b1);
    delay  = filter_order >> 1;
    if (decimation_factor == '0) begin
      factor = DECIM_BITS'(1);
    end else if (decimation_factor > DECIM_MAX) begin
      factor = DECIM_MAX;
    end else begin
      factor = decimation_factor;
    end
    lp_eff    = (line_pointer >= taps) ? '0 : line_pointer;
    lp_inc    = {1'b0, lp_eff} + 1'b1;
    lp_next   = (lp_inc >= {1'b0, taps}) ? '0 : lp_inc[TAP_BITS-1:0];
    phase_eff = ({1'b0, decimation_phase} >= factor) ? '0 : {1'b0, decimation_phase};
    phase_inc = phase_eff + 1'b1;
    coef_start = (lp_next == '0) ? '0 : taps - lp_next;
    coef_inc  = {1'b0, coef_idx} + 1'b1;
    sample_wr = s_accept && (action == ACT_SAMPLE);
  end

  always_comb begin
    cell_ctrl.clr   = s_accept && (action == ACT_START);
    cell_ctrl.shift = (state == ST_RUN);

    mac_ctrl.issue     = (state == ST_RUN);
    mac_ctrl.first     = (sweep_idx == '0);
    mac_ctrl.last      = (sweep_idx == TAP_BITS'(MAX_TAPS - 1));
    mac_ctrl.valid_tap = (sweep_idx < taps);
    mac_ctrl.coef_addr = coef_idx;

    coef_wr.en   = s_accept && (action == ACT_LOAD) && (coeff_index < TAP_BITS'(MAX_TAPS));
    coef_wr.addr = coeff_index;
    coef_wr.data = coeff_value;
  end

  // ring of sample cells; a sweep rotates it once around back to rest
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    dfl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .load      (sample_wr && (lp_eff == TAP_BITS'(k))),
      .load_data (sample_value),
      .shift_in  (ring[(k + 1) % MAX_TAPS]),
      .q         (ring[k])
    );
  end

  dfl_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .wr   (coef_wr),
    .ctrl (mac_ctrl),
    .head (ring[0]),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order      <= ORDER_RESET;
      decimation_factor <= DECIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ORDER) begin
        filter_order <= cfg_data;
      end else if (cfg_index == REG_DECIM) begin
        decimation_factor <= cfg_data[DECIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      line_pointer     <= '0;
      warmup_count     <= '0;
      decimation_phase <= '0;
      sweep_idx        <= '0;
      coef_idx         <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            unique case (action)
              ACT_START: begin
                line_pointer     <= '0;
                warmup_count     <= '0;
                decimation_phase <= '0;
              end
              ACT_SAMPLE: begin
                line_pointer <= lp_next;
                if (warmup_count < delay) begin
                  warmup_count <= warmup_count + 1'b1;
                end else if (phase_eff != '0) begin
                  decimation_phase <= (phase_inc >= factor) ? '0
                                                            : phase_inc[PHASE_BITS-1:0];
                end else begin
                  decimation_phase <= (factor <= DECIM_BITS'(1)) ? '0 : PHASE_BITS'(1);
                  sweep_idx        <= '0;
                  coef_idx         <= coef_start;
                  state            <= ST_RUN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          sweep_idx <= sweep_idx + 1'b1;
          coef_idx  <= (coef_inc >= {1'b0, taps}) ? '0 : coef_inc[TAP_BITS-1:0];
          if (mac_ctrl.last) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= res.value;
      m_tuser[0] <= res.sat;
    end
  end

  a_result_in_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(res.ready) |-> (state == ST_WAIT))
    else $error("mac result finished outside the wait state");

  a_pointer_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (line_pointer < taps))
    else $error("line pointer beyond tap count during sweep");

  a_coef_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (coef_idx < taps))
    else $error("coefficient address beyond tap count");

endmodule

>>> rtl/dfl_cell.sv
module dfl_cell import dfl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctrl_t                    ctrl,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] load_data,
  input  logic signed [SAMPLE_BITS-1:0] shift_in,
  output logic signed [SAMPLE_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      q <= '0;
    end else if (load) begin
      q <= load_data;
    end else if (ctrl.shift) begin
      q <= shift_in;
    end
  end

endmodule

>>> rtl/dfl_mac.sv
module dfl_mac import dfl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  coef_wr_t                      wr,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0] head,
  output mac_res_t                      res
);

  localparam int SH_BITS = ACC_BITS - ROUND_SHIFT;
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(2**(ROUND_SHIFT-1));
  localparam logic signed [SH_BITS-1:0] SH_MAX = SH_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [SH_BITS-1:0] SH_MIN = -SH_MAX - SH_BITS'(1);

  logic signed [COEFF_BITS-1:0]  coef_mem [MAX_TAPS];
  logic signed [COEFF_BITS-1:0]  coef_q;
  logic signed [SAMPLE_BITS-1:0] samp_b;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [ACC_BITS-1:0]    acc_rnd;
  logic signed [SH_BITS-1:0]     sh;
  logic                          vb, lb, vc, lc, ld;
  logic                          res_ready;
  logic signed [SAMPLE_BITS-1:0] res_value;
  logic                          res_sat;

  assign res = '{ready: res_ready, value: res_value, sat: res_sat};

  always_comb begin
    acc_rnd = acc + ROUND_HALF;
    sh      = $signed(acc_rnd[ACC_BITS-1:ROUND_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      coef_mem[wr.addr] <= wr.data;
    end
    if (ctrl.issue) begin
      coef_q <= coef_mem[ctrl.coef_addr];
    end
    samp_b <= head;
    prod   <= coef_q * samp_b;
    if (ctrl.issue && ctrl.first) begin
      acc <= '0;
    end else if (vc) begin
      acc <= acc + ACC_BITS'(prod);
    end
    if (ld) begin
      if (sh > SH_MAX) begin
        res_value <= SAMPLE_BITS'(SH_MAX);
        res_sat   <= 1'b1;
      end else if (sh < SH_MIN) begin
        res_value <= SAMPLE_BITS'(SH_MIN);
        res_sat   <= 1'b1;
      end else begin
        res_value <= sh[SAMPLE_BITS-1:0];
        res_sat   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb        <= 1'b0;
      lb        <= 1'b0;
      vc        <= 1'b0;
      lc        <= 1'b0;
      ld        <= 1'b0;
      res_ready <= 1'b0;
    end else begin
      vb <= ctrl.issue && ctrl.valid_tap;
      lb <= ctrl.issue && ctrl.last;
      vc <= vb;
      lc <= lb;
      ld <= lc;
      if (ctrl.issue && ctrl.first) begin
        res_ready <= 1'b0;
      end else if (ld) begin
        res_ready <= 1'b1;
      end
    end
  end

endmodule
